// ===== rtl/core/ritoa_pkg.sv =====
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared widths, constants and the digit-to-character lookup for the
// radix integer to ascii unit.
// ----------------------------------------------------------------------------
package ritoa_pkg;

  localparam int VALUE_W       = 64;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 6;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 64;

  // dividend bits consumed per division cycle
  localparam int BITS_PER_STEP = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 6'd36;

  // 0..9 -> '0'..'9', 10..35 -> 'a'..'z', anything else -> 0
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    begin
      if (d < DIGIT_TEN) begin
        c = CHAR_ZERO + {2'b00, d};
      end else if (d < DIGIT_LIMIT) begin
        c = CHAR_LOWER_A + {2'b00, d} - {2'b00, DIGIT_TEN};
      end else begin
        c = '0;
      end
      return c;
    end
  endfunction

endpackage

// ===== rtl/core/ritoa_if.sv =====
// ----------------------------------------------------------------------------
// ritoa channel interfaces
// Valid/ready channels for the value input, the character output and the
// radix configuration write.
// ----------------------------------------------------------------------------
interface ritoa_in_if;
  logic                         valid;
  logic                         ready;
  logic [ritoa_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ritoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ritoa_pkg::CHAR_W-1:0]  digit_char;
  logic                          last;
  logic                          empty_res;

  modport source (output valid, output digit_char, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input digit_char, input last, input empty_res,
                  output ready);
endinterface

interface ritoa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ritoa_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

// ===== rtl/core/ritoa_ram.sv =====
// ----------------------------------------------------------------------------
// ritoa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ritoa_ram #(
  parameter int WIDTH = ritoa_pkg::DIGIT_W,
  parameter int DEPTH = ritoa_pkg::MAX_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/radix_integer_to_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit
// Converts an unsigned integer to ascii digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// usage:
//   cfg_ch  : writes the radix (reset 10); only 2..36 convert, any other base
//             returns one word with empty_res and last set and digit_char 0
//   in_ch   : one word per value; only the low VALUE_BITS bits are used
//   out_ch  : one word per character, most significant digit first, last set
//             on the final character; zero gives the single character '0'
// timing:
//   a shared 8-bit-per-cycle restoring divider divides the whole value by the
//   radix once for each digit, digits go to a small ram
//   the characters are then read back from the ram, each one as a ram read,
//   then an output word
//   in_ch.ready is high only while idle, one value is in flight at a time
//   at most MAX_DIGITS digits are kept (the least significant ones)
// reset: returns to idle, radix goes to 10, no output word pending
// stall: the output word holds while out_ch.ready is low
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_unit #(
  parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = ritoa_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ritoa_cfg_if.sink  cfg_ch,
  ritoa_in_if.sink   in_ch,
  ritoa_out_if.source out_ch
);
  import ritoa_pkg::*;

  localparam int BPS       = BITS_PER_STEP;
  localparam int DIV_STEPS = (VALUE_BITS + BPS - 1) / BPS;
  localparam int QW        = DIV_STEPS * BPS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int AW        = $clog2(MAX_DIGITS);
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [QW-1:0]      work_r, work_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               empty_r, empty_nxt;
  logic [RADIX_W-1:0] radix_r;

  logic [DIGIT_W-1:0] rem_v;
  logic [DIGIT_W:0]   trial;
  logic [BPS-1:0]     qbits;
  logic [QW-1:0]      work_div;
  logic               step_last;
  logic               radix_ok;
  logic [CNT_W-1:0]   cnt_inc, cnt_dec;
  logic               in_acc, out_acc;

  logic               ram_we;
  logic [DIGIT_W-1:0] ram_rdata;

  assign radix_ok  = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
  assign step_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign cnt_inc   = count_r + CNT_W'(1);
  assign cnt_dec   = count_r - CNT_W'(1);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;

  // eight restoring division steps on the top byte of the work register
  always_comb begin
    rem_v = rem_r;
    trial = '0;
    qbits = '0;
    for (int i = 0; i < BPS; i++) begin
      trial = {rem_v, work_r[QW-1-i]};
      if (trial >= {1'b0, radix_r}) begin
        qbits[BPS-1-i] = 1'b1;
        trial = trial - {1'b0, radix_r};
      end
      rem_v = trial[DIGIT_W-1:0];
    end
  end

  assign work_div = (work_r << BPS) | QW'(qbits);
  assign ram_we   = (state_r == S_DIV) && step_last;

  ritoa_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(rem_v),
    .raddr(cnt_dec[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    empty_nxt = empty_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          count_nxt = '0;
          if (radix_ok) begin
            work_nxt  = QW'(in_ch.value[VALUE_BITS-1:0]);
            empty_nxt = 1'b0;
            state_nxt = S_DIV;
          end else begin
            work_nxt  = '0;
            empty_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        work_nxt = work_div;
        if (step_last) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          count_nxt = cnt_inc;
          // a zero value still gets its one digit
          if ((work_div == '0) || (cnt_inc >= CNT_W'(MAX_DIGITS))) begin
            state_nxt = S_READ;
          end
        end else begin
          rem_nxt  = rem_v;
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (out_ch.last) begin
            state_nxt = S_IDLE;
          end else begin
            count_nxt = cnt_dec;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      work_r  <= '0;
      count_r <= '0;
      step_r  <= '0;
      empty_r <= 1'b0;
      radix_r <= RADIX_RESET;
    end else begin
      state_r <= state_nxt;
      work_r  <= work_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      empty_r <= empty_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        radix_r <= cfg_ch.radix;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  // ram read address stays put during S_OUT, so its data holds under stall
  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.digit_char = empty_r ? '0 : digit_to_char(ram_rdata);
  assign out_ch.last       = empty_r || (count_r == CNT_W'(1));
  assign out_ch.empty_res  = empty_r;

endmodule

// ===== rtl/core/ritoa_chk.sv =====
// ----------------------------------------------------------------------------
// ritoa_chk
// Port-level checks for the radix integer to ascii unit, bound to the top.
// ----------------------------------------------------------------------------
module ritoa_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_digit_char,
  input logic       out_last,
  input logic       out_empty_res
);

  // no new value taken while characters are still going out
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while output word pending");

  // a value just taken keeps the input closed next cycle
  a_closed_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // empty string word is always a lone, zero, final word
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_last && (out_digit_char == 8'h00)))
    else $error("malformed empty word");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digit_char) && $stable(out_last)
       && $stable(out_empty_res)))
    else $error("output word changed under stall");

endmodule

bind radix_integer_to_ascii_unit ritoa_chk u_ritoa_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_digit_char(out_ch.digit_char),
  .out_last      (out_ch.last),
  .out_empty_res (out_ch.empty_res)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radix_integer_to_ascii_unit: values go in through a
// queue-fed driver, every character word coming out is compared against a
// digit-string predictor that follows the configured radix, valid and invalid.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ritoa_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam int MAX_DIGITS = MAX_DIGITS_DEF;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
  localparam string DIGIT_SYMBOLS = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_CYCLES = 800;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
  } char_word_t;

  logic clk;
  logic rst_n;

  ritoa_cfg_if cfg_if ();
  ritoa_in_if  in_if ();
  ritoa_out_if out_if ();

  radix_integer_to_ascii_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_if),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  logic [VALUE_W-1:0] pending_values[$];
  char_word_t         expected_chars[$];
  logic [RADIX_W-1:0] radix_now;

  int  cycle_count;
  int  mismatches;
  int  values_sent;
  int  chars_checked;
  int  radix_writes;
  bit  idle_on;
  bit  calm;
  int  send_gap;
  int  recv_stall;
  int  hold_left;
  int  holds_asked;
  int  holds_taken;

  // expected character words for one value at the given radix
  function automatic void queue_string(input logic [VALUE_W-1:0] value,
                                       input logic [RADIX_W-1:0] base);
    logic [DIGIT_W-1:0] digs[MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] base_wide;
    char_word_t w;
    int n;
    int k;
    n = 0;
    base_wide = VALUE_W'(base);
    rest = value & VALUE_MASK;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      w.ch = '0;
      w.last = 1'b1;
      w.empty = 1'b1;
      expected_chars.push_back(w);
      return;
    end
    if (rest == '0) begin
      digs[0] = '0;
      n = 1;
    end else begin
      while (rest != '0 && n < MAX_DIGITS) begin
        digs[n] = DIGIT_W'(rest % base_wide);
        rest = rest / base_wide;
        n++;
      end
    end
    for (k = n - 1; k >= 0; k--) begin
      w.ch = DIGIT_SYMBOLS[digs[k]];
      w.last = (k == 0);
      w.empty = 1'b0;
      expected_chars.push_back(w);
    end
  endfunction

  // values spread over digit counts, with powers of the base and the values just below them
  function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] base);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    logic [VALUE_W-1:0] b;
    int sel;
    sel = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    b = (base < RADIX_MIN || base > RADIX_MAX) ? VALUE_W'(10) : VALUE_W'(base);
    case (sel)
      0: v = '0;
      1: v = '1;
      2: v = VALUE_W'($urandom_range(0, 40));
      3, 4: begin
        p = VALUE_W'(1);
        repeat ($urandom_range(1, 64)) begin
          if (p <= {VALUE_W{1'b1}} / b) p = p * b;
        end
        v = p - VALUE_W'($urandom_range(0, 1));
      end
      5, 6: v = v >> $urandom_range(1, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h wanted 0x%0h", cycle_count, what,
             got, want);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_chars.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver: offers pending values, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.value <= '0;
      send_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        queue_string(in_if.value, radix_now);
        values_sent <= values_sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(0, 8);
            in_if.valid <= 1'b0;
          end else begin
            in_if.valid <= 1'b1;
            in_if.value <= pending_values.pop_front();
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_taken <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      hold_left <= LONG_HOLD;
      holds_taken <= holds_taken + 1;
    end
  end

  // monitor: checks each word and drives ready
  always @(posedge clk) begin
    char_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("word with nothing expected, char", VALUE_W'(out_if.digit_char),
                          '0);
        end else begin
          want = expected_chars.pop_front();
          if (out_if.digit_char !== want.ch)
            report_mismatch("digit_char", VALUE_W'(out_if.digit_char), VALUE_W'(want.ch));
          if (out_if.last !== want.last)
            report_mismatch("last", VALUE_W'(out_if.last), VALUE_W'(want.last));
          if (out_if.empty_res !== want.empty)
            report_mismatch("empty_res", VALUE_W'(out_if.empty_res), VALUE_W'(want.empty));
          chars_checked <= chars_checked + 1;
        end
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // block is idle once no value waits and no word is outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_if.valid || expected_chars.size() != 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.radix <= r;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    radix_now <= r;
    radix_writes++;
    @(negedge clk);
  endtask

  task automatic send_at(input logic [RADIX_W-1:0] r, input logic [VALUE_W-1:0] v);
    write_radix(r);
    pending_values.push_back(v);
    wait_drained();
  endtask

  initial begin
    logic [RADIX_W-1:0] phase_bases[9];
    logic [RADIX_W-1:0] base;
    int count;
    phase_bases = '{6'd16, 6'd2, 6'd36, 6'd8, 6'd40, 6'd7, 6'd3, 6'd5, 6'd10};
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.radix = '0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    radix_now = RADIX_RESET;
    cycle_count = 0;
    mismatches = 0;
    values_sent = 0;
    chars_checked = 0;
    radix_writes = 0;
    idle_on = 1'b1;
    calm = 1'b0;
    holds_asked = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // radix left at its reset value
    pending_values.push_back('0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back('1);
    pending_values.push_back(64'h8000_0000_0000_0000);
    wait_drained();

    // binary gives the longest strings
    write_radix(6'd2);
    pending_values.push_back('0);
    pending_values.push_back(64'd1);
    pending_values.push_back('1);
    pending_values.push_back(64'h8000_0000_0000_0000);
    wait_drained();

    write_radix(RADIX_MAX);
    pending_values.push_back(64'd35);
    pending_values.push_back(64'd36);
    pending_values.push_back('1);
    wait_drained();

    send_at(6'd16, 64'hfedc_ba98_7654_3210);
    send_at(6'd3, '1);

    // bases outside the valid range, including all-zero and all-one radix bits
    send_at(6'd0, 64'd12345);
    send_at(6'd1, '1);
    send_at(6'd37, 64'd36);
    send_at(6'd63, '0);

    for (int p = 0; p < 9; p++) begin
      base = phase_bases[p];
      count = 44;
      if (p == 4) begin
        base = RADIX_W'($urandom_range(37, 63));
        count = 12;
      end else if (p == 7) begin
        base = RADIX_W'($urandom_range(2, 36));
      end
      idle_on = (p % 3 != 2);
      calm = (p == 8);
      write_radix(base);
      for (int i = 0; i < count; i++) pending_values.push_back(pick_value(base));
      // output stalls long enough that the input backs up behind it
      if (p == 3) holds_asked = holds_asked + 1;
      wait_drained();
    end

    repeat (QUIET_CYCLES) @(negedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("words never delivered", VALUE_W'(expected_chars.size()), '0);

    $display("converted %0d values into %0d checked characters", values_sent, chars_checked);
    $display("over %0d radix writes, valid and invalid bases, with stalls and one long hold",
             radix_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== radix_integer_to_ascii_unit.f =====
rtl/core/ritoa_pkg.sv
rtl/core/ritoa_if.sv
rtl/core/ritoa_ram.sv
rtl/core/radix_integer_to_ascii_unit.sv
rtl/core/ritoa_chk.sv
tb/tb_top.sv
